### hdl/bfa_pkg.sv
// shared types and constants for the bitmap frame allocator
// no dependencies; imported by bfa_scan and bitmap_frame_allocator_core
package bfa_pkg;

  // default sizing of the bitmap
  localparam int MAX_FRAMES_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  // fixed field widths
  localparam int OP_W        = 3;
  localparam int IDX_W       = 12;
  localparam int LEN_W       = 13;
  localparam int CNT_W       = 13;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_MARK_USED  = 3'd0,
    OP_MARK_FREE  = 3'd1,
    OP_TEST       = 3'd2,
    OP_FIND_FIRST = 3'd3,
    OP_FIND_RUN   = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

endpackage

### hdl/bitmap_frame_allocator_core.sv
// bitmap page-frame allocator: one bit per physical frame kept in a ram,
// mark / test / find-first / find-run requests; uses bfa_pkg, bfa_ram, bfa_scan
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tuser: op; tdata: frame_index, run_length
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata: result_index, is_used, used_total, status
//   cfg       in   cfg_we_i (no back-pressure)   cfg_wdata_i: frame_count
//
// mark and test go through three steps: accept with ram read, read-modify-write, result load
// find first / find run scan one bitmap word per cycle from word 0 up to the last word
//   that the frame count reaches; the ram read port sets this pace
// after reset a clearing pass writes every bitmap word to zero, during which
//   no item is taken; cfg writes are taken always
// one item is in flight at a time; the output register lets the next item be
//   accepted while a result still waits on m_axis_tready
module bitmap_frame_allocator_core import bfa_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // frame count register
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_wdata_i,
  // request items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [11:0] frame_index, [24:12] run_length
  input  logic [OP_W-1:0]        s_axis_tuser,   // [2:0] op
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [11:0] result_index, [12] is_used,
                                                 // [25:13] used_total, [27:26] status
);

  localparam int WBL       = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(MAX_FRAMES + 1);
  localparam int CMPW      = (CW > CNT_W) ? CW : CNT_W;
  localparam int FW        = CMPW + 1;
  localparam int OUT_PAD   = OUT_TDATA_W - (IDX_W + 1 + CNT_W + STAT_W);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  // control state
  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_addr_q, clr_addr_d;
  logic [AW-1:0]          data_word_q, data_word_d;   // word whose data the ram returns now
  logic [CW-1:0]          used_cnt_q, used_cnt_d;
  logic [CNT_W-1:0]       frame_count_q;
  logic                   m_valid_q, m_valid_d;

  // item payload and pending result
  op_e                    op_q, op_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [FW-1:0]          run_q, run_d;
  logic [IDX_W-1:0]       res_idx_q, res_idx_d;
  logic                   res_used_q, res_used_d;
  status_e                res_stat_q, res_stat_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // ram port
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;

  // request fields
  op_e                    in_op;
  logic [IDX_W-1:0]       in_idx;
  logic [LEN_W-1:0]       in_len;
  logic                   in_range;
  logic [AW-1:0]          in_word;

  // live frame count and the last bitmap word it reaches
  logic [CMPW-1:0]        cnt_live;
  logic [CMPW-1:0]        cnt_m1;
  logic [AW-1:0]          last_word;
  logic [WBL-1:0]         last_bit;

  // mark / test word handling
  logic [AW-1:0]          idx_word_q;
  logic [WORD_BITS-1:0]   bit_mask;
  logic                   cur_bit;

  // scan step
  logic [WORD_BITS-1:0]   avail;
  logic [WORD_BITS-1:0]   free_vec;
  logic [FW-1:0]          scan_base;
  logic                   scan_found;
  logic [FW-1:0]          scan_start;
  logic [FW-1:0]          scan_run;

  assign in_op  = op_e'(s_axis_tuser);
  assign in_idx = s_axis_tdata[IDX_W-1:0];
  assign in_len = s_axis_tdata[IDX_W +: LEN_W];

  // effective count is the register clipped to the bitmap size
  assign cnt_live  = (CMPW'(frame_count_q) > CMPW'(MAX_FRAMES)) ? CMPW'(MAX_FRAMES)
                                                                 : CMPW'(frame_count_q);
  assign cnt_m1    = cnt_live - 1'b1;
  assign last_word = AW'(cnt_m1 >> WBL);
  assign last_bit  = cnt_m1[WBL-1:0];

  assign in_range   = CMPW'(in_idx) < cnt_live;
  assign in_word    = AW'(in_idx >> WBL);
  assign idx_word_q = AW'(idx_q >> WBL);
  assign bit_mask   = WORD_BITS'(1) << idx_q[WBL-1:0];
  assign cur_bit    = ram_rdata[idx_q[WBL-1:0]];

  // frames at or beyond the count look used to the search
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = (data_word_q != last_word) || (WBL'(b) <= last_bit);
    end
  end

  assign free_vec  = ~ram_rdata & avail;
  assign scan_base = FW'(data_word_q) << WBL;

  bfa_ram #(
    .WIDTH  (WORD_BITS),
    .DEPTH  (MAP_WORDS),
    .ADDR_W (AW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bfa_scan #(
    .WORD_BITS (WORD_BITS),
    .FW        (FW)
  ) u_scan (
    .free_i  (free_vec),
    .base_i  (scan_base),
    .run_i   (run_q),
    .len_i   (len_q),
    .found_o (scan_found),
    .start_o (scan_start),
    .run_o   (scan_run)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // sequencer: one item at a time, so a write-back always lands before the
  // next item's read and no forwarding is needed
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    data_word_d = data_word_q;
    used_cnt_d  = used_cnt_q;
    m_valid_d   = m_valid_q & ~m_axis_tready;
    op_d        = op_q;
    idx_d       = idx_q;
    len_d       = len_q;
    run_d       = run_q;
    res_idx_d   = res_idx_q;
    res_used_d  = res_used_q;
    res_stat_d  = res_stat_q;
    m_data_d    = m_data_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_addr_q;
    ram_wdata   = '0;
    ram_raddr   = data_word_q + 1'b1;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
        if (clr_addr_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d       = in_op;
          idx_d      = in_idx;
          // find first is a run of one; a zero length counts as one
          len_d      = (in_op == OP_FIND_FIRST || in_len == '0) ? LEN_W'(1) : in_len;
          res_idx_d  = '0;
          res_used_d = 1'b0;
          res_stat_d = STAT_OK;
          case (in_op)
            OP_MARK_USED, OP_MARK_FREE, OP_TEST: begin
              if (in_range) begin
                ram_raddr = in_word;
                state_d   = ST_WAIT;
              end else begin
                res_stat_d = STAT_RANGE;
                state_d    = ST_DONE;
              end
            end
            OP_FIND_FIRST, OP_FIND_RUN: begin
              if (cnt_live != '0) begin
                ram_raddr   = '0;
                data_word_d = '0;
                run_d       = '0;
                state_d     = ST_SCAN;
              end else begin
                res_stat_d = STAT_NONE;
                state_d    = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_WAIT: begin
        // word is back from the ram: test, or flip the bit and count it
        case (op_q)
          OP_TEST: begin
            res_used_d = cur_bit;
          end
          OP_MARK_USED: begin
            if (!cur_bit) begin
              ram_we     = 1'b1;
              ram_waddr  = idx_word_q;
              ram_wdata  = ram_rdata | bit_mask;
              used_cnt_d = used_cnt_q + 1'b1;
            end
          end
          OP_MARK_FREE: begin
            if (cur_bit) begin
              ram_we    = 1'b1;
              ram_waddr = idx_word_q;
              ram_wdata = ram_rdata & ~bit_mask;
              if (used_cnt_q != '0) begin
                used_cnt_d = used_cnt_q - 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        state_d = ST_DONE;
      end

      ST_SCAN: begin
        // the read of the next word is already issued by the default address
        if (scan_found) begin
          res_idx_d = IDX_W'(scan_start);
          state_d   = ST_DONE;
        end else if (data_word_q == last_word) begin
          res_stat_d = STAT_NONE;
          state_d    = ST_DONE;
        end else begin
          data_word_d = data_word_q + 1'b1;
          run_d       = scan_run;
        end
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {{OUT_PAD{1'b0}}, res_stat_q, CNT_W'(used_cnt_q),
                       res_used_q, res_idx_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      data_word_q   <= '0;
      used_cnt_q    <= '0;
      frame_count_q <= FRAME_COUNT_RST;
      m_valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      data_word_q <= data_word_d;
      used_cnt_q  <= used_cnt_d;
      m_valid_q   <= m_valid_d;
      if (cfg_we_i) begin
        frame_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    idx_q      <= idx_d;
    len_q      <= len_d;
    run_q      <= run_d;
    res_idx_q  <= res_idx_d;
    res_used_q <= res_used_d;
    res_stat_q <= res_stat_d;
    m_data_q   <= m_data_d;
  end

  // no item is taken while the bitmap is being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("item accepted during bitmap clear");

  // the used count only moves on a read-modify-write
  a_cnt_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_cnt_q != $past(used_cnt_q)) |-> ($past(state_q) == ST_WAIT))
    else $error("used count changed outside a mark");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q <= CW'(MAX_FRAMES))
    else $error("used count beyond frame capacity");

  // the search never writes the bitmap
  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !ram_we)
    else $error("bitmap written during search");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[IDX_W+1+CNT_W +: STAT_W] != 2'b11))
    else $error("undefined status on result");

endmodule

### hdl/bfa_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module bfa_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/bfa_scan.sv
// one-word step of the free-run search: checks a word of free bits against
// the run carried in from lower words; uses bfa_pkg
module bfa_scan import bfa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FW        = 14
) (
  input  logic [WORD_BITS-1:0] free_i,   // 1 = frame free and below the count
  input  logic [FW-1:0]        base_i,   // frame number of bit 0
  input  logic [FW-1:0]        run_i,    // free frames just below base_i
  input  logic [LEN_W-1:0]     len_i,    // wanted run length, at least 1
  output logic                 found_o,
  output logic [FW-1:0]        start_o,
  output logic [FW-1:0]        run_o     // run carried into the next word
);

  localparam int WBL = $clog2(WORD_BITS);
  localparam int PW  = WBL + 1;

  logic [PW-1:0]        head_free;
  logic [PW-1:0]        tail_free;
  logic [PW-1:0]        hit_pos;
  logic [PW-1:0]        off;
  logic [WORD_BITS-1:0] win [WBL+1];
  logic [WORD_BITS-1:0] fit;
  logic [FW:0]          head_sum;
  logic                 head_hit;
  logic                 fit_hit;

  // free stretch at the bottom and at the top of the word
  always_comb begin
    head_free = PW'(WORD_BITS);
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!free_i[b]) head_free = PW'(b);
    end
    tail_free = PW'(WORD_BITS);
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!free_i[b]) tail_free = PW'(WORD_BITS - 1 - b);
    end
  end

  // win[j][s]: frames s .. s+2^j-1 all free inside this word
  always_comb begin
    win[0] = free_i;
    for (int j = 1; j <= WBL; j++) begin
      win[j] = win[j-1] & (win[j-1] >> (1 << (j - 1)));
    end
  end

  // combine power-of-two windows into a window of len_i frames
  always_comb begin
    fit = '1;
    off = '0;
    for (int j = WBL; j >= 0; j--) begin
      if (len_i[j]) begin
        fit = fit & (win[j] >> off);
        off = off + PW'(1 << j);
      end
    end
    hit_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (fit[b]) hit_pos = PW'(b);
    end
  end

  assign fit_hit  = (len_i <= LEN_W'(WORD_BITS)) && (|fit);
  assign head_sum = {1'b0, run_i} + (FW + 1)'(head_free);
  assign head_hit = head_sum >= (FW + 1)'(len_i);

  // a run that started below this word wins over one wholly inside it
  assign found_o = head_hit || fit_hit;
  assign start_o = head_hit ? (base_i - run_i) : (base_i + FW'(hit_pos));
  assign run_o   = (head_free == PW'(WORD_BITS)) ? (run_i + FW'(WORD_BITS))
                                                 : FW'(tail_free);

endmodule
